FILE: rtl/char_lcd_text_console_scroll_top_defines.svh
// Assertion macros shared by the console RTL modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CHAR_LCD_TEXT_CONSOLE_SCROLL_TOP_DEFINES_SVH
`define CHAR_LCD_TEXT_CONSOLE_SCROLL_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCDCON_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCDCON_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lcdcon_pkg.sv
// Shared constants, state encoding and control types for the display console.
// No dependencies; used by every module of the block.
package lcdcon_pkg;

  localparam int COLUMNS_DEF = 16;

  localparam logic [7:0] LINE_ONE  = 8'h80;
  localparam logic [7:0] LINE_TWO  = 8'hC0;
  localparam logic [7:0] LINE_MASK = 8'hC0;
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] SPACE     = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_SCR_HDR,
    ST_SCR_DATA,
    ST_SCR_MID,
    ST_SCR_BLANK,
    ST_SCR_TAIL,
    ST_PRE_CMD,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic clr;
  } shadow_ctl_t;

endpackage

FILE: rtl/lcdcon_shadow.sv
// Line-two shadow memory with registered read and per-entry valid bits.
// Depends on lcdcon_pkg and the assertion macro header.
`include "char_lcd_text_console_scroll_top_defines.svh"

module lcdcon_shadow #(
  parameter int COLUMNS = lcdcon_pkg::COLUMNS_DEF,
  localparam int COL_W = $clog2(COLUMNS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lcdcon_pkg::shadow_ctl_t ctl,
  input  logic [COL_W-1:0]        wr_addr,
  input  logic [7:0]              wr_data,
  input  logic [COL_W-1:0]        rd_addr,
  output logic [7:0]              rd_data
);

  logic [7:0]         mem [COLUMNS];
  logic [COLUMNS-1:0] vld;
  logic [7:0]         rd_q;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // An entry that was never written since the last clear reads as a space.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (ctl.clr) begin
        vld <= '0;
      end
      if (ctl.wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : lcdcon_pkg::SPACE;

  `LCDCON_ASSERT_NXT(a_clr_empties, clk, rst, ctl.clr && !ctl.wr_en, vld == '0,
                     "shadow clear left valid entries")

endmodule

FILE: rtl/lcdcon_ctrl.sv
// Console sequencer: decodes requests, steps through the transaction list and
// drives the output register. Depends on lcdcon_pkg and the macro header.
`include "char_lcd_text_console_scroll_top_defines.svh"

module lcdcon_ctrl #(
  parameter int COLUMNS = lcdcon_pkg::COLUMNS_DEF,
  localparam int COL_W = $clog2(COLUMNS)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    op,
  input  logic [7:0]              char_code,
  input  logic [7:0]              position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    is_data,
  output logic [7:0]              lcd_byte,
  output logic                    last,
  output lcdcon_pkg::shadow_ctl_t sh_ctl,
  output logic [COL_W-1:0]        sh_wr_addr,
  output logic [7:0]              sh_wr_data,
  output logic [COL_W-1:0]        sh_rd_addr,
  input  logic [7:0]              sh_rd_data
);

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [7:0] END_ONE = lcdcon_pkg::LINE_ONE + 8'(COLUMNS);
  localparam logic [7:0] END_TWO = lcdcon_pkg::LINE_TWO + 8'(COLUMNS);

  lcdcon_pkg::state_t state, state_next, dec_state;

  logic [7:0]       cursor;
  logic [7:0]       cmd;
  logic [7:0]       ch;
  logic             put_pending;
  logic [COL_W-1:0] col;

  logic             accept;
  logic             adv;
  logic [7:0]       dec_cursor;
  logic [7:0]       dec_cmd;
  logic             dec_put;
  logic             dec_clr;
  logic             in_range;

  logic             emit_valid;
  logic             emit_is_data;
  logic [7:0]       emit_byte;
  logic             emit_last;

  assign in_stall = (state != lcdcon_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign adv      = !out_valid || !out_stall;
  assign in_range = (cursor[7:6] == 2'b11) && (cursor[5:0] < 6'(COLUMNS));

  // Request decode.
  always_comb begin
    dec_state  = lcdcon_pkg::ST_PUT;
    dec_cursor = cursor;
    dec_cmd    = position;
    dec_put    = 1'b0;
    dec_clr    = 1'b0;
    if (op) begin
      dec_state  = lcdcon_pkg::ST_SINGLE;
      dec_cursor = position;
    end else if (char_code == lcdcon_pkg::CH_LF) begin
      dec_cursor = lcdcon_pkg::LINE_TWO;
      dec_cmd    = lcdcon_pkg::LINE_TWO;
      if (cursor[6]) begin
        dec_state = lcdcon_pkg::ST_SCR_HDR;
      end else begin
        dec_state = lcdcon_pkg::ST_SINGLE;
      end
    end else if (char_code == lcdcon_pkg::CH_FF) begin
      dec_state  = lcdcon_pkg::ST_SINGLE;
      dec_cursor = lcdcon_pkg::LINE_ONE;
      dec_cmd    = lcdcon_pkg::CMD_CLEAR;
      dec_clr    = 1'b1;
    end else if (char_code == lcdcon_pkg::CH_CR) begin
      dec_state  = lcdcon_pkg::ST_SINGLE;
      dec_cursor = cursor & lcdcon_pkg::LINE_MASK;
      dec_cmd    = cursor & lcdcon_pkg::LINE_MASK;
    end else if (cursor == END_ONE) begin
      dec_state  = lcdcon_pkg::ST_PRE_CMD;
      dec_cursor = lcdcon_pkg::LINE_TWO;
    end else if (cursor == END_TWO) begin
      dec_state  = lcdcon_pkg::ST_SCR_HDR;
      dec_cursor = lcdcon_pkg::LINE_TWO;
      dec_put    = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lcdcon_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = dec_state;
        end
      end
      lcdcon_pkg::ST_SINGLE: begin
        if (adv) begin
          state_next = lcdcon_pkg::ST_IDLE;
        end
      end
      lcdcon_pkg::ST_SCR_HDR: begin
        if (adv) begin
          state_next = lcdcon_pkg::ST_SCR_DATA;
        end
      end
      lcdcon_pkg::ST_SCR_DATA: begin
        if (adv && col == LAST_COL) begin
          state_next = lcdcon_pkg::ST_SCR_MID;
        end
      end
      lcdcon_pkg::ST_SCR_MID: begin
        if (adv) begin
          state_next = lcdcon_pkg::ST_SCR_BLANK;
        end
      end
      lcdcon_pkg::ST_SCR_BLANK: begin
        if (adv && col == LAST_COL) begin
          state_next = lcdcon_pkg::ST_SCR_TAIL;
        end
      end
      lcdcon_pkg::ST_SCR_TAIL: begin
        if (adv) begin
          state_next = put_pending ? lcdcon_pkg::ST_PUT : lcdcon_pkg::ST_IDLE;
        end
      end
      lcdcon_pkg::ST_PRE_CMD: begin
        if (adv) begin
          state_next = lcdcon_pkg::ST_PUT;
        end
      end
      lcdcon_pkg::ST_PUT: begin
        if (adv) begin
          state_next = lcdcon_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lcdcon_pkg::ST_IDLE;
      end
    endcase
  end

  // Transaction produced in the current state.
  always_comb begin
    emit_valid   = 1'b1;
    emit_is_data = 1'b0;
    emit_byte    = lcdcon_pkg::LINE_TWO;
    emit_last    = 1'b0;
    case (state)
      lcdcon_pkg::ST_IDLE: begin
        emit_valid = 1'b0;
      end
      lcdcon_pkg::ST_SINGLE: begin
        emit_byte = cmd;
        emit_last = 1'b1;
      end
      lcdcon_pkg::ST_SCR_HDR: begin
        emit_byte = lcdcon_pkg::LINE_ONE;
      end
      lcdcon_pkg::ST_SCR_DATA: begin
        emit_is_data = 1'b1;
        emit_byte    = sh_rd_data;
      end
      lcdcon_pkg::ST_SCR_MID: begin
        emit_byte = lcdcon_pkg::LINE_TWO;
      end
      lcdcon_pkg::ST_SCR_BLANK: begin
        emit_is_data = 1'b1;
        emit_byte    = lcdcon_pkg::SPACE;
      end
      lcdcon_pkg::ST_SCR_TAIL: begin
        emit_last = !put_pending;
      end
      lcdcon_pkg::ST_PRE_CMD: begin
        emit_byte = lcdcon_pkg::LINE_TWO;
      end
      lcdcon_pkg::ST_PUT: begin
        emit_is_data = 1'b1;
        emit_byte    = ch;
        emit_last    = 1'b1;
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  // Shadow access. The read address runs one entry ahead while the output
  // register accepts, and repeats the current entry while it is held.
  always_comb begin
    sh_ctl.wr_en = (state == lcdcon_pkg::ST_PUT) && adv && in_range;
    sh_ctl.clr   = (accept && dec_clr) ||
                   ((state == lcdcon_pkg::ST_SCR_TAIL) && adv);
    sh_wr_addr   = cursor[COL_W-1:0];
    sh_wr_data   = ch;
    sh_rd_addr   = '0;
    if (state == lcdcon_pkg::ST_SCR_DATA) begin
      sh_rd_addr = (adv && col != LAST_COL) ? col + COL_W'(1) : col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lcdcon_pkg::ST_IDLE;
      cursor      <= lcdcon_pkg::LINE_ONE;
      put_pending <= 1'b0;
      col         <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        cursor      <= dec_cursor;
        put_pending <= dec_put;
        col         <= '0;
      end
      if (adv) begin
        out_valid <= emit_valid;
        case (state)
          lcdcon_pkg::ST_SCR_DATA, lcdcon_pkg::ST_SCR_BLANK: begin
            col <= (col == LAST_COL) ? '0 : col + COL_W'(1);
          end
          lcdcon_pkg::ST_PUT: begin
            cursor <= cursor + 8'd1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= dec_cmd;
      ch  <= char_code;
    end
    if (adv) begin
      is_data  <= emit_is_data;
      lcd_byte <= emit_byte;
      last     <= emit_last;
    end
  end

  `LCDCON_ASSERT_NXT(a_accept_busy, clk, rst, accept, state != lcdcon_pkg::ST_IDLE,
                     "accepted request produced no transaction")
  `LCDCON_ASSERT_NXT(a_last_idle, clk, rst, adv && emit_valid && emit_last,
                     state == lcdcon_pkg::ST_IDLE && out_valid && last,
                     "final transaction did not end the request")
  `LCDCON_ASSERT_NXT(a_data_loaded, clk, rst,
                     adv && state == lcdcon_pkg::ST_SCR_DATA,
                     out_valid && is_data && !last,
                     "scroll copy byte not loaded as data")

endmodule

FILE: rtl/char_lcd_text_console_scroll_top.sv
// Top level of the two-line character display console.
// Depends on lcdcon_pkg, lcdcon_shadow and lcdcon_ctrl.
//
// Usage: each request on the input channel (in_valid / in_stall) is either a
// character to print (op = 0, char_code) or a set-position command (op = 1,
// position). The block answers with one or more display bus transactions on
// the output channel (out_valid / out_stall): is_data selects command or data
// byte, lcd_byte carries it, and last marks the final one of each request.
// Requests are handled one at a time. Once a request is taken, the sequencer
// loads one transaction per cycle into the output register while the receiver
// does not stall it: a single one for a plain character or command, and for a
// character that forces a scroll a copy of line two to line one, a blanked
// line two and the line-two address command, then the character itself if
// it caused the wrap. The sequencer reads the line-two shadow memory one entry
// per cycle during a scroll while the output register accepts.
// A new request is taken as soon as the last transaction of the previous one
// sits in the output register, even while that result is still stalled.
// When the receiver stalls, the output register holds its transaction and the
// sequencer waits. Reset puts the cursor at the start of line one and makes
// the whole shadow read as spaces at once; no clearing pass is needed.

module char_lcd_text_console_scroll_top #(
  parameter int COLUMNS = lcdcon_pkg::COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] char_code,
  input  logic [7:0] position,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       is_data,
  output logic [7:0] lcd_byte,
  output logic       last
);

  localparam int COL_W = $clog2(COLUMNS);

  // Control and data between the sequencer and the shadow memory.
  lcdcon_pkg::shadow_ctl_t sh_ctl;
  logic [COL_W-1:0]        sh_wr_addr;
  logic [7:0]              sh_wr_data;
  logic [COL_W-1:0]        sh_rd_addr;
  logic [7:0]              sh_rd_data;

  lcdcon_ctrl #(
    .COLUMNS (COLUMNS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .char_code  (char_code),
    .position   (position),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_data    (is_data),
    .lcd_byte   (lcd_byte),
    .last       (last),
    .sh_ctl     (sh_ctl),
    .sh_wr_addr (sh_wr_addr),
    .sh_wr_data (sh_wr_data),
    .sh_rd_addr (sh_rd_addr),
    .sh_rd_data (sh_rd_data)
  );

  // The shadow holds the characters written to line two so that a scroll can
  // copy them up to line one without reading the display back.
  lcdcon_shadow #(
    .COLUMNS (COLUMNS)
  ) u_shadow (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sh_ctl),
    .wr_addr (sh_wr_addr),
    .wr_data (sh_wr_data),
    .rd_addr (sh_rd_addr),
    .rd_data (sh_rd_data)
  );

endmodule
